// ===== rtl/core/isv_pkg.sv =====
// Shared types, constants and the FNV-1a absorb step for the image signature verifier.
// No dependencies; imported by every module of the block.
package isv_pkg;

    localparam logic [63:0] OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] HASH_PRIME   = 64'h0000_0100_0000_01b3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTH_KEY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIG  = 2'd1;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } item_t;

    // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product mod 2^64
    // reduces to a sum of shifted copies: 0x1b3 = bits 8,7,5,4,1,0.
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/core/isv_front.sv =====
// Front stage: accepts input items and registers them as classified items.
// Depends on isv_pkg for item_t.
module isv_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_code_byte,
    input  logic           s_last_byte,
    output logic           item_valid,
    input  logic           item_ready,
    output isv_pkg::item_t item
);
    import isv_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t front_item_reg;

    assign s_ready    = !front_valid_reg || item_ready;
    assign item_valid = front_valid_reg;
    assign item       = front_item_reg;

    always_comb begin
        front_valid_next = front_valid_reg;
        if (s_valid && s_ready) begin
            front_valid_next = 1'b1;
        end else if (item_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_item_reg.code <= s_code_byte;
            front_item_reg.last <= s_last_byte;
        end
    end

endmodule

// ===== rtl/core/isv_queue.sv =====
// Small FIFO of classified items between the front and back stages.
// Depends on isv_pkg for item_t.
module isv_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  isv_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output isv_pkg::item_t pop_item
);
    import isv_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_pop_only_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count did not drop on pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/core/isv_back.sv =====
// Back stage: runs the FNV-1a hash, closes an image on its last byte, then
// checks the signature into the result register. Depends on isv_pkg.
module isv_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    output logic           item_ready,
    input  isv_pkg::item_t item,
    input  logic [63:0]    auth_key,
    input  logic [63:0]    expected_signature,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_image_ok,
    output logic [63:0]    m_digest
);
    import isv_pkg::*;

    logic [63:0] hash_reg, hash_next;
    logic [63:0] hash_step;
    logic        fin_valid_reg, fin_valid_next;
    logic [63:0] fin_digest_reg;
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [63:0] out_digest_reg;
    logic        out_ready;
    logic        fin_adv;
    logic        pop;

    assign out_ready  = !out_valid_reg || m_ready;
    assign fin_adv    = fin_valid_reg && out_ready;
    // A plain byte never waits; a last byte needs room in the finish stage.
    assign item_ready = !item.last || !fin_valid_reg || fin_adv;
    assign pop        = item_valid && item_ready;
    assign hash_step  = fnv_absorb(hash_reg, item.code);

    assign m_valid    = out_valid_reg;
    assign m_image_ok = out_ok_reg;
    assign m_digest   = out_digest_reg;

    always_comb begin
        hash_next      = hash_reg;
        fin_valid_next = fin_valid_reg;
        out_valid_next = out_valid_reg;
        if (pop) begin
            hash_next = item.last ? OFFSET_BASIS : hash_step;
        end
        if (pop && item.last) begin
            fin_valid_next = 1'b1;
        end else if (fin_adv) begin
            fin_valid_next = 1'b0;
        end
        if (fin_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= OFFSET_BASIS;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            hash_reg      <= hash_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.last) begin
            fin_digest_reg <= hash_step;
        end
        if (fin_adv) begin
            out_digest_reg <= fin_digest_reg;
            out_ok_reg     <= ((fin_digest_reg ^ auth_key) == expected_signature);
        end
    end

    a_reload_basis: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && item.last |=> hash_reg == OFFSET_BASIS)
        else $error("hash not reloaded after last byte");

    a_fin_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && item.last |=> fin_valid_reg && fin_digest_reg == $past(hash_step))
        else $error("finished digest not captured");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !fin_adv |=> fin_valid_reg && $stable(fin_digest_reg))
        else $error("finished digest lost while output stalled");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fin_valid_reg))
        else $error("result raised without a finished digest");

endmodule

// ===== rtl/core/image_signature_verifier.sv =====
// Top level of the image signature verifier: config registers plus the
// front, queue and back stages. Depends on isv_pkg, isv_front, isv_queue, isv_back.
//
// Usage:
//   Stream image bytes on s_code_byte with s_last_byte high on the final byte,
//   using the s_valid/s_ready handshake. Each image yields one result on the
//   m_ channel: m_digest is the 64-bit FNV-1a hash of the image and
//   m_image_ok is high when digest XOR authentication key equals the expected
//   signature. Bytes not marked last produce no result.
//   Configuration: pulse cfg_wr_en with cfg_index (0 = authentication key,
//   1 = expected signature) and cfg_wr_data; other indexes are ignored.
//   Write only while the block is idle.
//   Throughput: one byte per cycle unless a stalled result backs up, set by
//   the back stage hash update (multiply by the prime as a sum of shifted copies).
//   Path: after the last byte is accepted, the result passes the front register,
//   the queue, the finish stage and the result register.
//   Reset: registers clear to zero, the hash loads the offset basis and all
//   stages empty. When m_ready is low the result holds; the back stage keeps
//   absorbing bytes into one more image in the finish stage; a later last byte waits.
module image_signature_verifier #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [isv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_code_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_image_ok,
    output logic [63:0]                   m_digest
);
    import isv_pkg::*;

    logic [63:0] auth_key_reg, auth_key_next;
    logic [63:0] expected_sig_reg, expected_sig_next;

    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    always_comb begin
        auth_key_next     = auth_key_reg;
        expected_sig_next = expected_sig_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_AUTH_KEY:     auth_key_next     = cfg_wr_data;
                CFG_EXPECTED_SIG: expected_sig_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auth_key_reg     <= '0;
            expected_sig_reg <= '0;
        end else begin
            auth_key_reg     <= auth_key_next;
            expected_sig_reg <= expected_sig_next;
        end
    end

    isv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .s_last_byte (s_last_byte),
        .item_valid  (front_valid),
        .item_ready  (front_ready),
        .item        (front_item)
    );

    isv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    isv_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item_valid         (queue_valid),
        .item_ready         (queue_ready),
        .item               (queue_item),
        .auth_key           (auth_key_reg),
        .expected_signature (expected_sig_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_image_ok         (m_image_ok),
        .m_digest           (m_digest)
    );

endmodule

// ===== verif/image_signature_verifier_tb.sv =====
// Self-checking testbench for image_signature_verifier: FNV-1a image hashing and
// signature compare, checked against an in-bench predictor with a queue of verdicts.
// Depends on isv_pkg and the image_signature_verifier RTL.
module image_signature_verifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isv_pkg::*;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    // Well-known FNV-1a 64 digests of the one-byte images "a" and NUL
    localparam logic [63:0] DIGEST_A   = 64'haf63_dc4c_8601_ec8c;
    localparam logic [63:0] DIGEST_NUL = 64'haf63_bd4c_8601_b7df;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    localparam int TARGET_BYTES = 550;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] digest;
    } verdict_t;

    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  code;
        logic        last;
        bit          known;
        verdict_t    want;
        cfg_idx_t    idx;
        logic [63:0] data;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_code_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_image_ok;
    logic [63:0]          m_digest;

    image_signature_verifier u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_image_ok  (m_image_ok),
        .m_digest    (m_digest)
    );

    // Predictor state: running hash plus shadow copies of the two registers
    logic [63:0] model_hash = FNV_BASIS;
    logic [63:0] model_key = '0;
    logic [63:0] model_sig = '0;
    verdict_t    pending_verdicts[$];
    dir_row_t    dir_rows[$];
    cfg_idx_t    idx_pool[4] = '{CFG_AUTH_KEY, CFG_EXPECTED_SIG, CFG_IDX_SPARE2, CFG_IDX_SPARE3};

    int errors = 0;
    int bytes_sent = 0;
    int images_seen = 0;
    int images_ok_seen = 0;
    int burst_left = 0;
    int cycles = 0;
    bit sender_bursty = 1'b1;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic void add_byte(input logic [7:0] code, input logic last);
        dir_row_t r;
        r = '{kind: ROW_BYTE, code: code, last: last, known: 1'b0, want: '0,
              idx: '0, data: '0};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_known(input logic [7:0] code, input logic ok,
                                      input logic [63:0] digest);
        dir_row_t r;
        r = '{kind: ROW_BYTE, code: code, last: 1'b1, known: 1'b1,
              want: '{ok: ok, digest: digest}, idx: '0, data: '0};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_write(input cfg_idx_t idx, input logic [63:0] data);
        dir_row_t r;
        r = '{kind: ROW_WRITE, code: '0, last: 1'b0, known: 1'b0, want: '0,
              idx: idx, data: data};
        dir_rows.push_back(r);
    endfunction

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Lower valid, wait for every verdict, then let the pipeline settle
    task automatic drain_images();
        idle_sender(1);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
        drain_images();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_AUTH_KEY) model_key = data;
        else if (idx == CFG_EXPECTED_SIG) model_sig = data;
    endtask

    task automatic push_byte(input logic [7:0] code, input logic last, input bit known,
                             input verdict_t known_v);
        logic [63:0] h;
        verdict_t    v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_bursty && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_code_byte <= code;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        h = fnv_fold(model_hash, code);
        if (last) begin
            v.ok = ((h ^ model_key) == model_sig);
            v.digest = h;
            pending_verdicts.push_back(known ? known_v : v);
            model_hash = FNV_BASIS;
        end else begin
            model_hash = h;
        end
    endtask

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: image_ok=%0b digest=%h", m_image_ok, m_digest);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_image_ok !== want.ok) begin
                    $error("image_ok: expected %0b, got %0b", want.ok, m_image_ok);
                    errors++;
                end
                if (m_digest !== want.digest) begin
                    $error("digest: expected %h, got %h", want.digest, m_digest);
                    errors++;
                end
                images_seen++;
                if (m_image_ok) images_ok_seen++;
            end
        end
    end

    // Receiver: stretches of always-ready, coin-flip, and mostly-stalled
    initial begin : result_sink
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60)) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  img[$];
        logic [63:0] d;
        logic [63:0] val;
        int          img_len;
        int          split_at;

        add_known(8'h61, 1'b0, DIGEST_A);
        add_known(8'h00, 1'b0, DIGEST_NUL);
        add_write(CFG_EXPECTED_SIG, DIGEST_NUL);
        add_known(8'h00, 1'b1, DIGEST_NUL);
        add_write(CFG_AUTH_KEY, '1);
        add_write(CFG_EXPECTED_SIG, ~DIGEST_NUL);
        add_known(8'h00, 1'b1, DIGEST_NUL);
        // spare indexes must leave both registers alone
        add_write(CFG_IDX_SPARE2, '1);
        add_write(CFG_IDX_SPARE3, '0);
        add_known(8'h00, 1'b1, DIGEST_NUL);
        add_known(8'h61, 1'b0, DIGEST_A);
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7f, 1'b1);
        // registers change in the middle of an image
        add_byte(8'h12, 1'b0);
        add_write(CFG_EXPECTED_SIG, '0);
        add_write(CFG_AUTH_KEY, '0);
        add_byte(8'h34, 1'b1);
        add_byte(8'h55, 1'b0);
        add_byte(8'haa, 1'b0);
        add_byte(8'h01, 1'b1);
        add_write(CFG_EXPECTED_SIG, '1);
        add_known(8'h61, 1'b0, DIGEST_A);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                push_byte(dir_rows[i].code, dir_rows[i].last, dir_rows[i].known,
                          dir_rows[i].want);
        end

        while (bytes_sent < TARGET_BYTES) begin
            sender_bursty = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: val = '0;
                1: val = '1;
                default: val = {$urandom, $urandom};
            endcase
            write_reg(CFG_AUTH_KEY, val);
            case ($urandom_range(0, 2))
                0: val = '0;
                1: val = '1;
                default: val = {$urandom, $urandom};
            endcase
            write_reg(CFG_EXPECTED_SIG, val);

            repeat ($urandom_range(3, 8)) begin
                img_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 96)
                                                       : $urandom_range(1, 12);
                img.delete();
                d = FNV_BASIS;
                repeat (img_len) begin
                    img.push_back(8'($urandom));
                    d = fnv_fold(d, img[$]);
                end
                // make this image sign correctly a good share of the time
                if ($urandom_range(0, 2) == 0) write_reg(CFG_EXPECTED_SIG, d ^ model_key);
                split_at = (img_len > 1 && $urandom_range(0, 9) == 0)
                         ? $urandom_range(1, img_len - 1) : 0;
                foreach (img[i]) begin
                    if (split_at != 0 && i == split_at)
                        write_reg(idx_pool[$urandom_range(0, 3)], {$urandom, $urandom});
                    push_byte(img[i], (i == img_len - 1), 1'b0, '0);
                end
            end
        end

        drain_images();
        $display("Checked %0d images over %0d bytes; %0d verdicts passed the signature",
                 images_seen, bytes_sent, images_ok_seen);
        $display("Mixed bursty and steady input with stalls, mid-image register writes");
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/isv_pkg.sv
rtl/core/isv_front.sv
rtl/core/isv_queue.sv
rtl/core/isv_back.sv
rtl/core/image_signature_verifier.sv
verif/image_signature_verifier_tb.sv
